// ----- rtl/core/keyframe_vertex_blend_bbox_assert.svh -----
// Assertion macros for the keyframe vertex blend block.
`ifndef KEYFRAME_VERTEX_BLEND_BBOX_ASSERT_SVH
`define KEYFRAME_VERTEX_BLEND_BBOX_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KVB_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define KVB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define KVB_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define KVB_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/kvb_pkg.sv -----
// Shared types and constants of the keyframe vertex blend block.
`default_nettype none
package kvb_pkg;

    localparam int VAL_W   = 32;
    localparam int T_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_T     = 1'd1;

    // interpolation modes
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_CATMULL = 1'b1;

    localparam logic [T_W-1:0]          T_ONE   = 17'h10000;
    localparam logic signed [VAL_W-1:0] W_ONE   = 32'sh4000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]              component_sel;
        logic signed [VAL_W-1:0] frame0_value;
        logic signed [VAL_W-1:0] frame1_value;
        logic signed [VAL_W-1:0] frame2_value;
        logic signed [VAL_W-1:0] frame3_value;
        logic                    last_of_mesh;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] blended_value;
        logic signed [VAL_W-1:0] box_min;
        logic signed [VAL_W-1:0] box_max;
        logic                    saturated;
    } t_out_item;

    // classified word handed from the front queue to the back pipeline
    typedef struct packed {
        logic                    is_pos;
        logic [1:0]              axis;
        logic                    last;
        logic signed [VAL_W-1:0] f0;
        logic signed [VAL_W-1:0] f1;
        logic signed [VAL_W-1:0] f2;
        logic signed [VAL_W-1:0] f3;
    } t_work;

    // blend weights, signed Q2.30
    typedef struct packed {
        logic signed [VAL_W-1:0] w0;
        logic signed [VAL_W-1:0] w1;
        logic signed [VAL_W-1:0] w2;
        logic signed [VAL_W-1:0] w3;
    } t_weights;

endpackage
`default_nettype wire

// ----- rtl/core/kvb_weights.sv -----
// Configuration registers and the sequencer that derives the four blend weights.
`default_nettype none
module kvb_weights
    import kvb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       o_busy,
    output t_weights                   o_weights
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SQUARE = 2'd1;
    localparam logic [1:0] S_CUBE   = 2'd2;
    localparam logic [1:0] S_WEIGHT = 2'd3;

    localparam logic signed [55:0] ONE2   = 56'sh2_0000_0000_0000;
    localparam logic signed [55:0] HALF_W = 56'sd262144;

    logic             r_mode;
    logic [T_W-1:0]   r_blend_t;
    logic [1:0]       r_state, n_state;
    logic [32:0]      r_t2;
    logic [48:0]      r_t3;
    t_weights         r_w, n_w;

    logic [T_W-1:0]   w_t;
    logic signed [55:0] w_x3, w_x2, w_x1;

    // round half up from 2^-49 units to Q2.30
    function automatic logic signed [VAL_W-1:0] round_w(input logic signed [55:0] x);
        logic signed [55:0] y;
        y = (x + HALF_W) >>> 19;
        return y[VAL_W-1:0];
    endfunction

    assign w_t  = (r_blend_t > T_ONE) ? T_ONE : r_blend_t;
    assign w_x3 = signed'({7'd0, r_t3});
    assign w_x2 = signed'({7'd0, r_t2, 16'd0});
    assign w_x1 = signed'({7'd0, w_t, 32'd0});

    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        unique case (r_state)
            S_IDLE:   n_state = S_IDLE;
            S_SQUARE: n_state = S_CUBE;
            S_CUBE:   n_state = S_WEIGHT;
            S_WEIGHT: begin
                n_state = S_IDLE;
                if (r_mode == MODE_CATMULL) begin
                    n_w.w0 = round_w((w_x2 <<< 1) - w_x3 - w_x1);
                    n_w.w1 = round_w(w_x3 * 3 - w_x2 * 5 + ONE2);
                    n_w.w2 = round_w((w_x2 <<< 2) - w_x3 * 3 + w_x1);
                    n_w.w3 = round_w(w_x3 - w_x2);
                end else begin
                    n_w.w0 = '0;
                    n_w.w1 = signed'({1'b0, T_ONE - w_t, 14'd0});
                    n_w.w2 = signed'({1'b0, w_t, 14'd0});
                    n_w.w3 = '0;
                end
            end
            default:  n_state = S_IDLE;
        endcase
        // any write restarts the derivation
        if (i_cfg_wr_en) begin
            n_state = S_SQUARE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_LINEAR;
            r_blend_t <= '0;
            r_w       <= '{w0: '0, w1: W_ONE, w2: '0, w3: '0};
        end else begin
            r_state <= n_state;
            r_w     <= n_w;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_INTERP_MODE: r_mode    <= i_cfg_wdata[0];
                    CFG_BLEND_T:     r_blend_t <= i_cfg_wdata[T_W-1:0];
                    default:         r_mode    <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SQUARE) begin
            r_t2 <= 33'(w_t) * 33'(w_t);
        end
        if (r_state == S_CUBE) begin
            r_t3 <= 49'(r_t2) * 49'(w_t);
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_weights = r_w;

endmodule
`default_nettype wire

// ----- rtl/core/kvb_front.sv -----
// Input side: accepts items, classifies the component and queues the work.
`default_nettype none
module kvb_front
    import kvb_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    input  wire logic     i_hold,
    output logic          o_work_valid,
    input  wire logic     i_work_ready,
    output t_work         o_work
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    t_work             w_entry;
    logic              w_push, w_pop;

    always_comb begin
        w_entry.is_pos = (i_in_data.component_sel < 3'd3);
        w_entry.axis   = i_in_data.component_sel[1:0];
        w_entry.last   = i_in_data.last_of_mesh;
        w_entry.f0     = i_in_data.frame0_value;
        w_entry.f1     = i_in_data.frame1_value;
        w_entry.f2     = i_in_data.frame2_value;
        w_entry.f3     = i_in_data.frame3_value;
    end

    assign o_in_ready   = (r_count != CNT_W'(DEPTH)) && !i_hold;
    assign o_work_valid = (r_count != '0);
    assign o_work       = r_mem[r_rd_ptr];
    assign w_push       = i_in_valid && o_in_ready;
    assign w_pop        = o_work_valid && i_work_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/kvb_back.sv -----
// Execution side: weighted sum pipeline, rounding, saturation and box tracking.
`default_nettype none
module kvb_back
    import kvb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_work_valid,
    output logic          o_work_ready,
    input  wire t_work    i_work,
    input  wire t_weights i_weights,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    localparam logic signed [65:0] HALF_R = 66'sd536870912;
    localparam logic signed [35:0] R_MAX  = 36'sd2147483647;
    localparam logic signed [35:0] R_MIN  = -36'sd2147483648;

    typedef struct packed {
        logic       is_pos;
        logic [1:0] axis;
        logic       last;
    } t_meta;

    logic               w_adv;
    logic               r1_valid, r2_valid, r3_valid, r_out_valid;
    t_meta              r1_meta, r2_meta, r3_meta;
    logic signed [63:0] r1_p0, r1_p1, r1_p2, r1_p3;
    logic signed [64:0] r2_s01, r2_s23;
    logic signed [VAL_W-1:0] r3_value;
    logic               r3_sat;
    t_out_item          r_out;

    logic signed [VAL_W-1:0] r_box_min [3];
    logic signed [VAL_W-1:0] r_box_max [3];
    logic [2:0]              r_axis_empty;

    logic signed [65:0] w_acc;
    logic signed [35:0] w_round;
    logic signed [VAL_W-1:0] w_min, w_max;

    // hold every stage while the output word waits
    assign w_adv        = !r_out_valid || i_out_ready;
    assign o_work_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid    <= i_work_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    // four products, then two pair sums
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_meta <= '{is_pos: i_work.is_pos, axis: i_work.axis, last: i_work.last};
            r1_p0   <= i_work.f0 * i_weights.w0;
            r1_p1   <= i_work.f1 * i_weights.w1;
            r1_p2   <= i_work.f2 * i_weights.w2;
            r1_p3   <= i_work.f3 * i_weights.w3;
            r2_meta <= r1_meta;
            r2_s01  <= 65'(r1_p0) + 65'(r1_p1);
            r2_s23  <= 65'(r1_p2) + 65'(r1_p3);
        end
    end

    assign w_acc   = 66'(r2_s01) + 66'(r2_s23) + HALF_R;
    assign w_round = 36'(w_acc >>> 30);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_meta <= r2_meta;
            if (w_round > R_MAX) begin
                r3_value <= VAL_MAX;
                r3_sat   <= 1'b1;
            end else if (w_round < R_MIN) begin
                r3_value <= VAL_MIN;
                r3_sat   <= 1'b1;
            end else begin
                r3_value <= w_round[VAL_W-1:0];
                r3_sat   <= 1'b0;
            end
        end
    end

    // box update for the selected axis; an empty axis takes the value as is
    always_comb begin
        w_min = r3_value;
        w_max = r3_value;
        for (int i = 0; i < 3; i++) begin
            if (r3_meta.axis == 2'(i) && !r_axis_empty[i]) begin
                w_min = (r3_value < r_box_min[i]) ? r3_value : r_box_min[i];
                w_max = (r3_value > r_box_max[i]) ? r3_value : r_box_max[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_empty <= '1;
            for (int i = 0; i < 3; i++) begin
                r_box_min[i] <= VAL_MAX;
                r_box_max[i] <= VAL_MIN;
            end
        end else if (w_adv && r3_valid) begin
            if (r3_meta.last) begin
                r_axis_empty <= '1;
                for (int i = 0; i < 3; i++) begin
                    r_box_min[i] <= VAL_MAX;
                    r_box_max[i] <= VAL_MIN;
                end
            end else if (r3_meta.is_pos) begin
                for (int i = 0; i < 3; i++) begin
                    if (r3_meta.axis == 2'(i)) begin
                        r_box_min[i]    <= w_min;
                        r_box_max[i]    <= w_max;
                        r_axis_empty[i] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.blended_value <= r3_value;
            r_out.saturated     <= r3_sat;
            r_out.box_min       <= r3_meta.is_pos ? w_min : '0;
            r_out.box_max       <= r3_meta.is_pos ? w_max : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- rtl/core/keyframe_vertex_blend_bbox.sv -----
// Top level of the keyframe vertex blend block with running position box.
//
//  channel   direction  handshake                      word
//  in        input      i_in_valid / o_in_ready        t_in_item
//  out       output     o_out_valid / i_out_ready      t_out_item
//  cfg       input      i_cfg_wr_en (no wait)          i_cfg_index, i_cfg_wdata
//
// One word per cycle is sustained while the output is ready and no config write or
// weight derivation holds the input. A word leaves the queue with the products, then
// passes pair sum, round and clip, and box update into the output register.
// A configuration write starts the weight derivation (square, cube, weights);
// o_in_ready is low during it and during the write itself.
// Reset clears the queue, the pipeline valids, the box and the registers.
// A stalled output holds the whole back pipeline; the queue keeps taking words until full.
`default_nettype none
module keyframe_vertex_blend_bbox
    import kvb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic     w_wgt_busy;
    t_weights w_weights;
    logic     w_work_valid, w_work_ready;
    t_work    w_work;
    logic     w_out_sat, w_out_at_limit, w_box_ok;

    kvb_weights u_weights (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (w_wgt_busy),
        .o_weights   (w_weights)
    );

    kvb_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_hold       (w_wgt_busy || i_cfg_wr_en),
        .o_work_valid (w_work_valid),
        .i_work_ready (w_work_ready),
        .o_work       (w_work)
    );

    kvb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (w_work_valid),
        .o_work_ready (w_work_ready),
        .i_work       (w_work),
        .i_weights    (w_weights),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    assign w_out_sat      = o_out_valid && o_out_data.saturated;
    assign w_out_at_limit = (o_out_data.blended_value == VAL_MAX) ||
                            (o_out_data.blended_value == VAL_MIN);
    assign w_box_ok       = (o_out_data.box_min <= o_out_data.box_max);

`include "keyframe_vertex_blend_bbox_assert.svh"

    `KVB_ASSERT_IMPLY(a_busy_blocks_input, i_clk, i_rst_n, w_wgt_busy, !o_in_ready)
    `KVB_ASSERT_NEXT(a_write_starts_update, i_clk, i_rst_n, i_cfg_wr_en, w_wgt_busy)
    `KVB_ASSERT_IMPLY(a_sat_at_limit, i_clk, i_rst_n, w_out_sat, w_out_at_limit)
    `KVB_ASSERT_IMPLY(a_box_ordered, i_clk, i_rst_n, o_out_valid, w_box_ok)

endmodule
`default_nettype wire

// ----- bench/keyframe_vertex_blend_bbox_tb.sv -----
// Self-checking bench for the keyframe vertex blend block with running position box.
module keyframe_vertex_blend_bbox_tb;
    import kvb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [79:0] t_wide;

    localparam t_wide SAT_HI = 80'sd2147483647;
    localparam t_wide SAT_LO = -80'sd2147483648;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // blend configuration and box state as the block should hold them
    logic                    cfg_mode = MODE_LINEAR;
    logic [T_W-1:0]          cfg_t = '0;
    logic signed [VAL_W-1:0] box_lo [3];
    logic signed [VAL_W-1:0] box_hi [3];
    logic                    box_empty [3];

    t_out_item blend_results_q [$];
    int        mismatch_cnt = 0;
    int        hold_left = 0;
    bit        tx_idle_on = 1'b0;
    bit        rx_idle_on = 1'b0;

    keyframe_vertex_blend_bbox dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_box_model();
        for (int a = 0; a < 3; a++) begin
            box_lo[a]    = VAL_MAX;
            box_hi[a]    = VAL_MIN;
            box_empty[a] = 1'b1;
        end
    endfunction

    // add half an LSB, then floor
    function automatic t_wide round_sh(t_wide x, int s);
        return (x + (t_wide'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_out_item blend_vertex(t_in_item w);
        t_wide f0, f1, f2, f3, t, t1, t2, t3, w0, w1, w2, w3, acc, r;
        logic [1:0] ax;
        t_out_item res;
        f0 = t_wide'($signed(w.frame0_value));
        f1 = t_wide'($signed(w.frame1_value));
        f2 = t_wide'($signed(w.frame2_value));
        f3 = t_wide'($signed(w.frame3_value));
        t  = t_wide'((cfg_t > T_ONE) ? T_ONE : cfg_t);
        if (cfg_mode == MODE_LINEAR) begin
            acc = (f1 <<< 16) + (f2 - f1) * t;
            r   = round_sh(acc, 16);
        end else begin
            // cubic weights in units of 2^-49, rounded to Q2.30
            t3  = t * t * t;
            t2  = (t * t) <<< 16;
            t1  = t <<< 32;
            w0  = round_sh(-t3 + 2 * t2 - t1, 19);
            w1  = round_sh(3 * t3 - 5 * t2 + (t_wide'(1) <<< 49), 19);
            w2  = round_sh(-3 * t3 + 4 * t2 + t1, 19);
            w3  = round_sh(t3 - t2, 19);
            acc = f0 * w0 + f1 * w1 + f2 * w2 + f3 * w3;
            r   = round_sh(acc, 30);
        end
        res = '0;
        if (r > SAT_HI) begin
            r = SAT_HI;
            res.saturated = 1'b1;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
            res.saturated = 1'b1;
        end
        res.blended_value = r[VAL_W-1:0];
        if (w.component_sel < 3) begin
            ax = w.component_sel[1:0];
            if (box_empty[ax]) begin
                box_lo[ax]    = res.blended_value;
                box_hi[ax]    = res.blended_value;
                box_empty[ax] = 1'b0;
            end else begin
                if (res.blended_value < box_lo[ax]) box_lo[ax] = res.blended_value;
                if (res.blended_value > box_hi[ax]) box_hi[ax] = res.blended_value;
            end
            res.box_min = box_lo[ax];
            res.box_max = box_hi[ax];
        end
        if (w.last_of_mesh) clear_box_model();
        return res;
    endfunction

    function automatic int pause_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3: return $urandom;
            default: return int'($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic t_in_item make_item(logic [2:0] sel, logic signed [VAL_W-1:0] f0,
                                           logic signed [VAL_W-1:0] f1,
                                           logic signed [VAL_W-1:0] f2,
                                           logic signed [VAL_W-1:0] f3, logic last);
        t_in_item w;
        w.component_sel = sel;
        w.frame0_value  = f0;
        w.frame1_value  = f1;
        w.frame2_value  = f2;
        w.frame3_value  = f3;
        w.last_of_mesh  = last;
        return w;
    endfunction

    // Entered and left at a falling edge; valid stays high for a back-to-back word.
    task automatic send_word(input t_in_item word);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pause_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= word;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (blend_results_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic load_blend_cfg(input logic [CFG_DATA_W-1:0] mode_word,
                                  input logic [CFG_DATA_W-1:0] t_word);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_INTERP_MODE;
        i_cfg_wdata <= mode_word;
        @(posedge i_clk);
        cfg_mode = mode_word[0];
        @(negedge i_clk);
        i_cfg_index <= CFG_BLEND_T;
        i_cfg_wdata <= t_word;
        @(posedge i_clk);
        cfg_t = t_word;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Meshes of random length, mostly position words; some end without a last flag.
    task automatic send_meshes(input int n_words);
        int sent, len;
        bit keep_last;
        t_in_item w;
        sent = 0;
        while (sent < n_words) begin
            len       = $urandom_range(1, 12);
            keep_last = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    w = make_item(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                                  $urandom, 1'($urandom_range(0, 1)));
                end else begin
                    w = make_item(3'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 2)
                                                                 : $urandom_range(3, 7)),
                                  rand_value(), rand_value(), rand_value(), rand_value(),
                                  keep_last && (k == len - 1));
                end
                send_word(w);
                sent++;
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_word(make_item(3'd0, 32'sh7654_3210, 32'sh1234_5678, VAL_MIN, VAL_MAX, 1'b0));
        send_word(make_item(3'd0, 32'sd0, -32'sd5, 32'sd9, 32'sd0, 1'b1));
    endtask

    task automatic test_linear_directed();
        load_blend_cfg(17'(MODE_LINEAR), 17'h0_8000);
        send_word(make_item(3'd1, 32'sd0, VAL_MIN, VAL_MAX, 32'sd0, 1'b0));
        send_word(make_item(3'd1, 32'sd0, VAL_MAX, VAL_MIN, 32'sd0, 1'b0));
        // half an LSB either way: round up
        send_word(make_item(3'd2, VAL_MAX, 32'sd0, 32'sd1, VAL_MIN, 1'b0));
        send_word(make_item(3'd2, VAL_MIN, 32'sd0, -32'sd1, VAL_MAX, 1'b0));
        send_word(make_item(3'd3, 32'sd7, 32'sd100, 32'sd200, 32'sd7, 1'b1));
        // upper mode bits ignored, t above one clamps
        load_blend_cfg(17'h1_FFFE, 17'h1_FFFF);
        send_word(make_item(3'd0, $urandom, 32'sd3, VAL_MAX, $urandom, 1'b0));
        send_word(make_item(3'd7, $urandom, $urandom, $urandom, $urandom, 1'b1));
    endtask

    task automatic test_catmull_directed();
        load_blend_cfg(17'(MODE_CATMULL), 17'h0_8000);
        send_word(make_item(3'd0, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, 1'b0));
        send_word(make_item(3'd0, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX, 1'b0));
        send_word(make_item(3'd5, $urandom, $urandom, $urandom, $urandom, 1'b1));
        load_blend_cfg(17'(MODE_CATMULL), 17'h0_0000);
        send_word(make_item(3'd1, $urandom, $urandom, $urandom, $urandom, 1'b0));
        load_blend_cfg(17'(MODE_CATMULL), 17'(T_ONE));
        send_word(make_item(3'd1, $urandom, $urandom, $urandom, $urandom, 1'b1));
        load_blend_cfg(17'(MODE_CATMULL), 17'h0_0001);
        send_word(make_item(3'd2, $urandom, $urandom, $urandom, $urandom, 1'b1));
    endtask

    task automatic test_box_directed();
        load_blend_cfg(17'(MODE_LINEAR), 17'h0_0000);
        send_word(make_item(3'd0, 32'sd0, 32'sd5, 32'sd0, 32'sd0, 1'b0));
        send_word(make_item(3'd0, 32'sd0, -32'sd3, 32'sd0, 32'sd0, 1'b0));
        send_word(make_item(3'd0, 32'sd0, 32'sd9, 32'sd0, 32'sd0, 1'b0));
        send_word(make_item(3'd1, 32'sd0, 32'sd7, 32'sd0, 32'sd0, 1'b0));
        send_word(make_item(3'd6, 32'sd0, 32'sd1000, 32'sd0, 32'sd0, 1'b0));
        send_word(make_item(3'd0, 32'sd0, -32'sd3, 32'sd0, 32'sd0, 1'b1));
        send_word(make_item(3'd0, 32'sd0, 32'sd100, 32'sd0, 32'sd0, 1'b0));
        send_word(make_item(3'd2, 32'sd0, VAL_MIN, 32'sd0, 32'sd0, 1'b1));
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] t_word;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: t_word = '0;
                1: t_word = 17'(T_ONE);
                2: t_word = 17'h1_FFFF;
                3: t_word = 17'($urandom_range(65537, 131071));
                default: t_word = 17'($urandom_range(1, 65535));
            endcase
            load_blend_cfg({16'($urandom), 1'(p % 2)}, t_word);
            tx_idle_on = (p % 3 != 0);
            rx_idle_on = (p % 4 != 1);
            send_meshes(35);
        end
    endtask

    // Hold the output long enough to fill the block and stall its input.
    task automatic test_backpressure();
        load_blend_cfg(17'(MODE_CATMULL), 17'($urandom_range(1, 65535)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        @(posedge i_clk);
        hold_left = 100;
        @(negedge i_clk);
        send_meshes(40);
    endtask

    task automatic test_drained_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_meshes(15);
        wait_drained();
        send_meshes(15);
    endtask

    // receiver: long hold when asked, else random stalls while enabled
    initial begin : rx_stall
        int off_left;
        off_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (off_left > 0) begin
                i_out_ready <= 1'b0;
                off_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0) off_left = pause_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            blend_results_q.push_back(blend_vertex(i_in_data));
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (blend_results_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected word val=%h min=%h max=%h sat=%b", $time,
                             o_out_data.blended_value, o_out_data.box_min,
                             o_out_data.box_max, o_out_data.saturated);
            end else begin
                want = blend_results_q.pop_front();
                if (want.blended_value !== o_out_data.blended_value ||
                    want.box_min !== o_out_data.box_min ||
                    want.box_max !== o_out_data.box_max ||
                    want.saturated !== o_out_data.saturated) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"%0t: mismatch exp val=%h min=%h max=%h sat=%b, ",
                                  "got val=%h min=%h max=%h sat=%b"},
                                 $time, want.blended_value, want.box_min, want.box_max,
                                 want.saturated, o_out_data.blended_value,
                                 o_out_data.box_min, o_out_data.box_max,
                                 o_out_data.saturated);
                end
            end
        end
    end

    initial begin
        clear_box_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_linear_directed();
        test_catmull_directed();
        test_box_directed();
        test_random_phases();
        test_backpressure();
        test_drained_pause();
        wait_drained();
        // catch stray words after the last expected one
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0 && blend_results_q.size() == 0) begin
            $display("keyframe_vertex_blend_bbox_tb: done, clean");
        end else begin
            $display("keyframe_vertex_blend_bbox_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("keyframe_vertex_blend_bbox_tb: done, errors");
        $finish;
    end

endmodule
